FILE: hw/rtl/bfr_pkg.sv
// ============================================================================
// bfr_pkg
// Shared types and constants of the bitmap font text renderer.
// ============================================================================
package bfr_pkg;

    // Font geometry
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COUNT = 256;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);

    // Rows emitted per drawn character
    localparam int DRAW_ROWS = 16;
    localparam int ROW_W     = $clog2(DRAW_ROWS);

    // Cursor geometry
    localparam int X_W    = 13;
    localparam int Y_W    = 16;
    localparam int CELL_W = 8;
    localparam int LINE_H = 16;
    localparam logic [Y_W-1:0] Y_MAX = '1;

    // Field widths
    localparam int CODE_W   = 8;
    localparam int GROW_W   = 4;
    localparam int BITS_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int COLOR_W  = 32;
    localparam int SWIDTH_W = 13;
    localparam int PITCH_W  = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    // Function codes
    localparam logic [1:0] FUNC_FONT_WR = 2'd0;
    localparam logic [1:0] FUNC_DRAW    = 2'd1;
    localparam logic [1:0] FUNC_HOME    = 2'd2;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_NUL = 8'd0;
    localparam logic [CODE_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NL  = 8'd10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 2'd3;

    // Register reset values
    localparam logic [COLOR_W-1:0]  RST_DRAW_COLOR   = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0]   RST_FRAME_BASE   = 32'h0;
    localparam logic [SWIDTH_W-1:0] RST_SCREEN_WIDTH = 13'd640;
    localparam logic [PITCH_W-1:0]  RST_LINE_PITCH   = 14'd640;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_ROWS
    } bfr_state_t;

    typedef struct packed {
        logic font_wr;
        logic cur_clear;
        logic cur_nl;
        logic cur_adv;
        logic glyph_load;
        logic mul;
        logic base;
        logic issue;
    } bfr_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic row_last;
    } bfr_stat_t;

endpackage

FILE: hw/rtl/bfr_ram.sv
// ============================================================================
// bfr_ram
// Generic one-write, one-read RAM with registered, enabled read data.
// ============================================================================
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bfr_ctrl.sv
// ============================================================================
// bfr_ctrl
// Sequencer: decodes input words and steps a character through setup and rows.
// ============================================================================
module bfr_ctrl
    import bfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [CODE_W-1:0] char_code,
    input  bfr_stat_t         stat,
    output bfr_cmd_t          cmd
);

    bfr_state_t state_reg;
    bfr_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_DRAW && char_code != CODE_NUL
                    && char_code != CODE_NL && char_code != CODE_TAB)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_BASE;
            ST_BASE: state_next = ST_ROWS;
            ST_ROWS:
            begin
                if (stat.slot_free && stat.row_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_FONT_WR: cmd.font_wr = 1'b1;
                        FUNC_HOME:    cmd.cur_clear = 1'b1;
                        FUNC_DRAW:
                        begin
                            priority if (char_code == CODE_NUL)
                            begin
                                cmd.font_wr = 1'b0;
                            end
                            else if (char_code == CODE_NL)
                            begin
                                cmd.cur_nl = 1'b1;
                            end
                            else if (char_code == CODE_TAB)
                            begin
                                cmd.cur_adv = 1'b1;
                            end
                            else
                            begin
                                cmd.glyph_load = 1'b1;
                            end
                        end
                        default: cmd.font_wr = 1'b0;
                    endcase
                end
            end
            ST_MUL:  cmd.mul = 1'b1;
            ST_BASE:
            begin
                cmd.base    = 1'b1;
                cmd.cur_adv = 1'b1;
            end
            ST_ROWS: cmd.issue = stat.slot_free;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/bfr_datapath.sv
// ============================================================================
// bfr_datapath
// Config registers, cursor, font store, address generator and output stage.
// ============================================================================
module bfr_datapath
    import bfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [GROW_W-1:0]    glyph_row,
    input  logic [BITS_W-1:0]    row_bits,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  bfr_cmd_t             cmd,
    output bfr_stat_t            stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    row_address,
    output logic [BITS_W-1:0]    pixel_mask,
    output logic [COLOR_W-1:0]   pixel_value,
    output logic                 last_row
);

    function automatic logic [Y_W-1:0] line_down(input logic [Y_W-1:0] y);
        logic [Y_W-1:0] res;
        if (y > Y_W'(Y_MAX - Y_W'(LINE_H)))
        begin
            res = Y_MAX;
        end
        else
        begin
            res = y + Y_W'(LINE_H);
        end
        return res;
    endfunction

    // Config registers
    logic [COLOR_W-1:0]  draw_color_reg;
    logic [ADDR_W-1:0]   frame_base_reg;
    logic [SWIDTH_W-1:0] screen_width_reg;
    logic [PITCH_W-1:0]  line_pitch_reg;

    // Cursor
    logic [X_W-1:0] cur_x_reg;
    logic [X_W-1:0] cur_x_next;
    logic [Y_W-1:0] cur_y_reg;
    logic [Y_W-1:0] cur_y_next;
    logic [X_W-1:0] step_x;
    logic [Y_W-1:0] step_y;

    // Character work registers
    logic [GLYPH_W-1:0]        glyph_reg;
    logic [Y_W+PITCH_W-1:0]    prod_reg;
    logic [ADDR_W-1:0]         row_addr_reg;
    logic [ROW_W-1:0]          row_cnt_reg;

    // Output stage
    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;
    logic                 out_zero_reg;

    // Font store access
    logic                   wr_en;
    logic [STORE_AW-1:0]    wr_addr;
    logic [STORE_AW-1:0]    rd_addr;
    logic [STORE_AW-1:0]    rd_row;
    logic                   row_in_glyph;
    logic [BITS_W-1:0]      rd_data;
    logic [9:0]             code_ext;
    logic [9:0]             glyph_idx;
    logic [ADDR_W-1:0]      pitch4;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg   <= RST_DRAW_COLOR;
            frame_base_reg   <= RST_FRAME_BASE;
            screen_width_reg <= RST_SCREEN_WIDTH;
            line_pitch_reg   <= RST_LINE_PITCH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRAW_COLOR:   draw_color_reg   <= cfg_data[COLOR_W-1:0];
                CFG_FRAME_BASE:   frame_base_reg   <= cfg_data[ADDR_W-1:0];
                CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data[SWIDTH_W-1:0];
                CFG_LINE_PITCH:   line_pitch_reg   <= cfg_data[PITCH_W-1:0];
                default:          draw_color_reg   <= draw_color_reg;
            endcase
        end
    end

    // ---- cursor: move, then wrap when the next cell would not fit ----
    always_comb
    begin
        step_x = cmd.cur_nl ? '0 : cur_x_reg + X_W'(CELL_W);
        step_y = cmd.cur_nl ? line_down(cur_y_reg) : cur_y_reg;
        if ((X_W+1)'(step_x) + (X_W+1)'(CELL_W) > (X_W+1)'(screen_width_reg))
        begin
            step_x = '0;
            step_y = line_down(step_y);
        end
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        priority if (cmd.cur_clear)
        begin
            cur_x_next = '0;
            cur_y_next = '0;
        end
        else if (cmd.cur_nl || cmd.cur_adv)
        begin
            cur_x_next = step_x;
            cur_y_next = step_y;
        end
        else
        begin
            cur_x_next = cur_x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

    // ---- font store ----
    assign wr_en   = cmd.font_wr
                     && (10'(char_code) < 10'(GLYPH_COUNT))
                     && (6'(glyph_row) < 6'(GLYPH_ROWS));
    assign wr_addr = STORE_AW'(char_code) * STORE_AW'(GLYPH_ROWS) + STORE_AW'(glyph_row);

    assign row_in_glyph = (6'(row_cnt_reg) < 6'(GLYPH_ROWS));
    assign rd_row       = row_in_glyph ? STORE_AW'(row_cnt_reg) : '0;
    assign rd_addr      = STORE_AW'(glyph_reg) * STORE_AW'(GLYPH_ROWS) + rd_row;

    bfr_ram #(
        .WIDTH (BITS_W),
        .DEPTH (STORE_DEPTH)
    ) u_font_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (row_bits),
        .re    (cmd.issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ---- address generation ----
    assign code_ext  = 10'(char_code);
    assign glyph_idx = (code_ext >= 10'(GLYPH_COUNT)) ? code_ext - 10'(GLYPH_COUNT)
                                                       : code_ext;
    assign pitch4    = ADDR_W'({line_pitch_reg, 2'b00});

    always_ff @(posedge clk)
    begin
        if (cmd.glyph_load)
        begin
            glyph_reg <= GLYPH_W'(glyph_idx);
        end
        if (cmd.mul)
        begin
            prod_reg <= cur_y_reg * line_pitch_reg;
        end
        if (cmd.base)
        begin
            row_addr_reg <= frame_base_reg + ADDR_W'({cur_x_reg, 2'b00})
                            + ADDR_W'({prod_reg, 2'b00});
            row_cnt_reg  <= '0;
        end
        else if (cmd.issue)
        begin
            row_addr_reg <= row_addr_reg + pitch4;
            row_cnt_reg  <= row_cnt_reg + ROW_W'(1);
        end
    end

    // ---- output stage ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            out_addr_reg  <= row_addr_reg;
            out_color_reg <= draw_color_reg;
            out_last_reg  <= (row_cnt_reg == ROW_W'(DRAW_ROWS - 1));
            out_zero_reg  <= !row_in_glyph;
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.row_last  = (row_cnt_reg == ROW_W'(DRAW_ROWS - 1));

    assign out_valid   = out_valid_reg;
    assign row_address = out_addr_reg;
    assign pixel_mask  = out_zero_reg ? '0 : rd_data;
    assign pixel_value = out_color_reg;
    assign last_row    = out_last_reg;

endmodule

FILE: hw/rtl/bitmap_font_text_renderer_top.sv
// Usage: text console glyph engine for an 8x16 bitmap font.
// Input channel (in_valid/in_ready) carries one word per command: func 0
// writes row_bits into glyph char_code, row glyph_row of the font store;
// func 1 draws char_code at the cursor; func 2 homes the cursor.
// Output channel (out_valid/out_ready) carries one word per glyph row: the
// framebuffer byte address of the row, its pixel mask and the draw color,
// with last_row marking the sixteenth row of a character.
// Font writes, cursor commands, newline, tab and code zero leave the engine
// ready for the next word. A printed character goes through setup (y*pitch
// multiply, then base address) and then 16 rows, one font-store read and
// one row per cycle while the receiver does not stall; the single read port
// of the font store sets the row rate. The first row follows the accepted
// word through the multiply, base and row states and the output register.
// When the receiver stalls, the row sequencer holds and the font store read
// data holds; the next input word is taken while the final row still waits.
// Reset (rst_n, async, active low) homes the cursor and loads the register
// defaults; the font store is not cleared and must be written before use.
// Configuration writes (cfg_we/cfg_index/cfg_data) belong in idle periods.
// ============================================================================
// bitmap_font_text_renderer_top
// Top level: sequencer plus datapath of the bitmap font text renderer.
// ============================================================================
module bitmap_font_text_renderer_top
    import bfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [GROW_W-1:0]    glyph_row,
    input  logic [BITS_W-1:0]    row_bits,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // result words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    row_address,
    output logic [BITS_W-1:0]    pixel_mask,
    output logic [COLOR_W-1:0]   pixel_value,
    output logic                 last_row
);

    bfr_cmd_t  cmd;
    bfr_stat_t stat;

    // Sequencer: decode words, step setup and rows
    bfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .char_code (char_code),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: registers, cursor, font store, address and output stage
    bfr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .glyph_row   (glyph_row),
        .row_bits    (row_bits),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_address (row_address),
        .pixel_mask  (pixel_mask),
        .pixel_value (pixel_value),
        .last_row    (last_row)
    );

`ifndef SYNTHESIS
    // A pending row that is not the last one means the character is still
    // being drawn, so no new word may be taken.
    a_no_accept_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_row) |-> !in_ready)
        else $error("input taken while a character is still drawing");

    // Rows of one character follow back to back once the receiver takes one.
    a_rows_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_row) |=> out_valid)
        else $error("row sequence broke before the last row");

    // Hold a stalled row word unchanged until the receiver takes it.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(row_address)
            && $stable(pixel_mask) && $stable(pixel_value) && $stable(last_row)))
        else $error("stalled row word changed before it was taken");

    // A non-drawing word never leaves the engine busy.
    a_short_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func != FUNC_DRAW) |=> in_ready)
        else $error("non-drawing word did not complete in one cycle");
`endif

endmodule

FILE: tb/sv/bfr_row_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// bfr_row_checker
// Watches the command, configuration and row channels of the text renderer.
// It keeps its own font image, cursor and register copies, works out the row
// words each accepted command must produce and checks them in order.
// ============================================================================
module bfr_row_checker
    import bfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [GROW_W-1:0]    glyph_row,
    input  logic [BITS_W-1:0]    row_bits,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [ADDR_W-1:0]    row_address,
    input  logic [BITS_W-1:0]    pixel_mask,
    input  logic [COLOR_W-1:0]   pixel_value,
    input  logic                 last_row,
    output int                   outstanding,
    output int                   mismatches,
    output int                   rows_checked
);

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [BITS_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } row_word_t;

    row_word_t            pending_rows [$];
    logic [BITS_W-1:0]    font_image [STORE_DEPTH];
    logic [X_W-1:0]       caret_x;
    logic [Y_W-1:0]       caret_y;
    logic [COLOR_W-1:0]   ink_color;
    logic [ADDR_W-1:0]    fb_base;
    logic [SWIDTH_W-1:0]  vis_width;
    logic [PITCH_W-1:0]   pitch;
    int                   fault_count;

    assign mismatches = fault_count;

    // Move to the next text line, holding y at its ceiling.
    task automatic new_text_line();
        caret_x = '0;
        caret_y = (caret_y > Y_W'(Y_MAX - LINE_H)) ? Y_MAX : Y_W'(caret_y + LINE_H);
    endtask

    task automatic render_command(input logic [1:0] f, input logic [CODE_W-1:0] c,
                                  input logic [GROW_W-1:0] g, input logic [BITS_W-1:0] b);
        row_word_t     w;
        logic [31:0]   scan;
        case (f)
            FUNC_FONT_WR: font_image[STORE_AW'(c * GLYPH_ROWS + g)] = b;
            FUNC_HOME:
            begin
                caret_x = '0;
                caret_y = '0;
            end
            FUNC_DRAW:
            begin
                if (c != CODE_NUL)
                begin
                    if (c == CODE_NL)
                    begin
                        new_text_line();
                    end
                    else if (c == CODE_TAB)
                    begin
                        caret_x = X_W'(caret_x + CELL_W);
                    end
                    else
                    begin
                        for (int r = 0; r < DRAW_ROWS; r++)
                        begin
                            scan = 32'(caret_y) + 32'(r);
                            w.address = fb_base + 32'd4 * (32'(caret_x) + scan * 32'(pitch));
                            w.mask = (r < GLYPH_ROWS)
                                   ? font_image[STORE_AW'((c % GLYPH_COUNT) * GLYPH_ROWS + r)]
                                   : '0;
                            w.color = ink_color;
                            w.last = (r == DRAW_ROWS - 1);
                            pending_rows.push_back(w);
                        end
                        caret_x = X_W'(caret_x + CELL_W);
                    end
                    if (32'(caret_x) + CELL_W > 32'(vis_width))
                        new_text_line();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_word_t want;
        row_word_t got;
        if (!rst_n)
        begin
            pending_rows.delete();
            caret_x      = '0;
            caret_y      = '0;
            ink_color    = RST_DRAW_COLOR;
            fb_base      = RST_FRAME_BASE;
            vis_width    = RST_SCREEN_WIDTH;
            pitch        = RST_LINE_PITCH;
            fault_count  = 0;
            rows_checked <= 0;
            outstanding  <= 0;
        end
        else
        begin
            // Retire the oldest expectation before adding new ones.
            if (out_valid && out_ready)
            begin
                got = {row_address, pixel_mask, pixel_value, last_row};
                if (pending_rows.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected row word: addr %h mask %h value %h last %b",
                                 got.address, got.mask, got.color, got.last);
                end
                else
                begin
                    want = pending_rows.pop_front();
                    rows_checked <= rows_checked + 1;
                    if (got.address !== want.address || got.mask !== want.mask ||
                        got.color !== want.color || got.last !== want.last)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"row word mismatch: expected addr %h mask %h value %h ",
                                      "last %b, got addr %h mask %h value %h last %b"},
                                     want.address, want.mask, want.color, want.last,
                                     got.address, got.mask, got.color, got.last);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DRAW_COLOR:   ink_color = cfg_data;
                    CFG_FRAME_BASE:   fb_base   = cfg_data;
                    CFG_SCREEN_WIDTH: vis_width = cfg_data[SWIDTH_W-1:0];
                    CFG_LINE_PITCH:   pitch     = cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                render_command(func, char_code, glyph_row, row_bits);
            outstanding <= pending_rows.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench of the bitmap font text renderer.
// Loads glyphs, drives directed and random command words in bursts against a
// stalling receiver, and steps through several register settings; the row
// checker beside the block predicts and compares every row word.
// ============================================================================
module tb_top;
    import bfr_pkg::*;

    // func value the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // idle cycles allowed after the last row before the registers are touched
    localparam int SETTLE_CYCLES = 24;
    // cycles with no word accepted on either channel before giving up
    localparam int STALL_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           func = FUNC_FONT_WR;
    logic [CODE_W-1:0]    char_code = '0;
    logic [GROW_W-1:0]    glyph_row = '0;
    logic [BITS_W-1:0]    row_bits = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DRAW_COLOR;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ADDR_W-1:0]    row_address;
    logic [BITS_W-1:0]    pixel_mask;
    logic [COLOR_W-1:0]   pixel_value;
    logic                 last_row;

    int outstanding;
    int mismatches;
    int rows_checked;

    // Stimulus bookkeeping: which font rows are written, which glyphs are
    // complete and so safe to draw.
    logic [GLYPH_ROWS-1:0] rows_loaded [GLYPH_COUNT];
    logic                  listed [GLYPH_COUNT];
    logic [CODE_W-1:0]     drawable [$];
    int                    burst_left = 0;
    int                    words_sent = 0;
    int                    chars_drawn = 0;
    int                    settings = 0;

    always #10 clk = ~clk;

    bitmap_font_text_renderer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .char_code   (char_code),
        .glyph_row   (glyph_row),
        .row_bits    (row_bits),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_address (row_address),
        .pixel_mask  (pixel_mask),
        .pixel_value (pixel_value),
        .last_row    (last_row)
    );

    bfr_row_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .char_code    (char_code),
        .glyph_row    (glyph_row),
        .row_bits     (row_bits),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_address  (row_address),
        .pixel_mask   (pixel_mask),
        .pixel_value  (pixel_value),
        .last_row     (last_row),
        .outstanding  (outstanding),
        .mismatches   (mismatches),
        .rows_checked (rows_checked)
    );

    // Receiver: whenever ready_left runs out, pick a new stall style - always ready,
    // coin flip, mostly stalled, or mostly ready.
    int ready_mode = 0;
    int ready_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                ready_left = 48;
            end
            ready_left--;
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 5) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: end the run when neither channel moves a word for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
        $display("[bitmap_font_text_renderer_top] ERROR");
        $finish;
    end

    // Pick a character that draws a glyph (not terminator, tab or newline).
    function automatic logic [CODE_W-1:0] printable_code();
        logic [CODE_W-1:0] c;
        do
            c = CODE_W'($urandom);
        while (c == CODE_NUL || c == CODE_TAB || c == CODE_NL);
        return c;
    endfunction

    // Present one command word and hold it until accepted. At the start of
    // each burst, drop valid for a random gap (sometimes none).
    task automatic send_word(input logic [1:0] f, input logic [CODE_W-1:0] c,
                             input logic [GROW_W-1:0] g, input logic [BITS_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        func      <= f;
        char_code <= c;
        glyph_row <= g;
        row_bits  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (f == FUNC_FONT_WR)
        begin
            rows_loaded[c][g] = 1'b1;
            // Glyph becomes drawable once all its rows are written.
            if (&rows_loaded[c] && !listed[c] &&
                c != CODE_NUL && c != CODE_TAB && c != CODE_NL)
            begin
                listed[c] = 1'b1;
                drawable.push_back(c);
            end
        end
    endtask

    // Send a command word of the given func with scrambled payload.
    task automatic send_noise(input logic [1:0] f);
        send_word(f, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom));
    endtask

    // Draw command; glyph_row and row_bits are don't-care, so scramble them.
    task automatic put_char(input logic [CODE_W-1:0] c);
        if (c != CODE_NUL && c != CODE_TAB && c != CODE_NL)
            chars_drawn++;
        send_word(FUNC_DRAW, c, GROW_W'($urandom), BITS_W'($urandom));
    endtask

    // Write every row of one glyph; the first rows take the edge patterns.
    task automatic load_glyph(input logic [CODE_W-1:0] c);
        logic [BITS_W-1:0] pattern;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            case (r)
                0:       pattern = 8'hFF;
                1:       pattern = 8'h00;
                2:       pattern = 8'h80;
                3:       pattern = 8'h01;
                default: pattern = BITS_W'($urandom);
            endcase
            send_word(FUNC_FONT_WR, c, GROW_W'(r), pattern);
        end
    endtask

    // Drop valid and wait until every row word is back, then let any
    // non-drawing command still in flight finish.
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; call only while idle.
    // Upper bits above the narrow registers carry noise.
    task automatic program_regs(input logic [COLOR_W-1:0] color,
                                input logic [ADDR_W-1:0] base,
                                input logic [SWIDTH_W-1:0] width,
                                input logic [PITCH_W-1:0] pitch);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DRAW_COLOR;
        cfg_data  <= color;
        @(posedge clk);
        cfg_index <= CFG_FRAME_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= {(CFG_W - SWIDTH_W)'($urandom), width};
        @(posedge clk);
        cfg_index <= CFG_LINE_PITCH;
        cfg_data  <= {(CFG_W - PITCH_W)'($urandom), pitch};
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int                  pick;
        logic [COLOR_W-1:0]  color;
        logic [ADDR_W-1:0]   base;
        logic [SWIDTH_W-1:0] width;
        logic [PITCH_W-1:0]  pitch;

        for (int i = 0; i < GLYPH_COUNT; i++)
        begin
            rows_loaded[i] = '0;
            listed[i] = 1'b0;
        end

        // Hold reset low, once, then release it.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Glyphs at the code extremes plus a couple of ordinary ones.
        load_glyph(8'hFF);
        load_glyph(8'h01);
        load_glyph(8'h80);
        load_glyph(8'h7F);
        load_glyph(8'h41);

        // Directed pass at reset register values: every func, terminator,
        // tab, newline, unused func and home.
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h01);
        put_char(8'h80);
        put_char(8'h7F);
        put_char(CODE_NUL);
        put_char(CODE_TAB);
        put_char(8'h41);
        put_char(CODE_NL);
        put_char(8'hFF);
        send_word(FUNC_UNUSED, 8'hFF, 4'hF, 8'hFF);
        send_word(FUNC_UNUSED, 8'h00, 4'h0, 8'h00);
        send_word(FUNC_HOME, 8'hFF, 4'hF, 8'hFF);
        put_char(8'h80);
        // Rewrite a live glyph row, then draw with it.
        send_word(FUNC_FONT_WR, 8'h41, 4'hF, 8'hA5);
        put_char(8'h41);

        // Narrow screen: every character wraps. Base wraps past 2^32,
        // widest pitch, colour zero.
        drain_results();
        program_regs(32'h0, 32'hFFFF_FFFC, 13'd0, 14'h3FFF);
        put_char(8'hFF);
        put_char(CODE_TAB);
        put_char(CODE_NL);
        put_char(8'h41);
        put_char(CODE_NUL);
        put_char(8'h7F);

        // Widest screen, zero pitch: step x right with a run of tabs.
        drain_results();
        program_regs($urandom, $urandom, 13'h1FFF, 14'd0);
        send_noise(FUNC_HOME);
        for (int i = 0; i < 12; i++)
            put_char(CODE_TAB);
        put_char(8'hFF);
        put_char(8'h41);

        // Single-pixel pitch with the base at the top of the address space:
        // newlines move y down and the row addresses wrap past 2^32.
        drain_results();
        program_regs($urandom, 32'hFFFF_FFFF, 13'd640, 14'd1);
        for (int i = 0; i < 12; i++)
            put_char(CODE_NL);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(CODE_NL);
        put_char(8'h01);
        send_noise(FUNC_HOME);
        put_char(8'h80);

        // Random part: several register settings, mostly drawing with live
        // glyphs, mixed with control codes, font writes and the odd pause.
        for (int seg = 0; seg < 5; seg++)
        begin
            drain_results();
            case ($urandom_range(0, 2))
                0:       color = '0;
                1:       color = '1;
                default: color = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0:       base = '0;
                1:       base = '1;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       width = SWIDTH_W'($urandom_range(0, 7));
                1:       width = 13'h1FFF;
                2:       width = 13'd4096;
                3:       width = 13'd640;
                default: width = SWIDTH_W'($urandom_range(8, 8191));
            endcase
            case ($urandom_range(0, 4))
                0:       pitch = '0;
                1:       pitch = 14'h3FFF;
                2:       pitch = 14'd8192;
                default: pitch = PITCH_W'($urandom);
            endcase
            program_regs(color, base, width, pitch);
            for (int n = 0; n < 9; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    put_char(drawable[$urandom_range(0, drawable.size() - 1)]);
                else if (pick < 58)
                    put_char(CODE_NL);
                else if (pick < 64)
                    put_char(CODE_TAB);
                else if (pick < 68)
                    put_char(CODE_NUL);
                else if (pick < 72)
                    send_noise(FUNC_HOME);
                else if (pick < 75)
                    send_noise(FUNC_UNUSED);
                else if (pick < 90)
                    send_noise(FUNC_FONT_WR);
                else if (pick < 95)
                    load_glyph(printable_code());
                else
                    drain_results();
            end
        end

        drain_results();
        $display("covered %0d command words, %0d printed characters, %0d register settings",
                 words_sent, chars_drawn, settings);
        $display("%0d glyph row words checked, %0d mismatches", rows_checked, mismatches);
        if (mismatches == 0)
            $display("[bitmap_font_text_renderer_top] OK");
        else
            $display("[bitmap_font_text_renderer_top] ERROR");
        $finish;
    end

endmodule
